### src/rpd_pkg.sv
// Shared types and constants of the radar packet deframer.
`timescale 1ns / 1ps

package rpd_pkg;

   localparam int MAGIC_BYTES  = 8;
   localparam int HEADER_BYTES = 36;

   localparam logic [7:0] MAGIC_WORD [MAGIC_BYTES] = '{
      8'h02, 8'h01, 8'h04, 8'h03, 8'h06, 8'h05, 8'h08, 8'h07
   };
   localparam logic [7:0]  MAGIC_FIRST  = 8'h02;
   localparam logic [31:0] MAX_TLV_TYPE = 32'd3;

   localparam logic [2:0] PHASE_HUNT     = 3'd0;
   localparam logic [2:0] PHASE_HEADER   = 3'd1;
   localparam logic [2:0] PHASE_TLV_HEAD = 3'd2;
   localparam logic [2:0] PHASE_TLV_DATA = 3'd3;
   localparam logic [2:0] PHASE_OTHER    = 3'd4;

   localparam logic [3:0] WID_LENGTH     = 4'd1;
   localparam logic [3:0] WID_TLV_COUNT  = 4'd6;
   localparam logic [3:0] WID_TLV_TYPE   = 4'd7;
   localparam logic [3:0] WID_TLV_LENGTH = 4'd8;

   localparam logic [1:0] ERR_NONE      = 2'd0;
   localparam logic [1:0] ERR_SHORT     = 2'd1;
   localparam logic [1:0] ERR_LONG      = 2'd2;
   localparam logic [1:0] ERR_TLV_TYPE  = 2'd3;

   localparam logic [15:0] MAX_PACKET_RESET = 16'd4096;

   typedef enum logic [1:0] {
      SYNC_HUNT,
      SYNC_HEADER,
      SYNC_TLV,
      SYNC_OTHER
   } sync_state_type;

   typedef struct packed {
      logic       hit;
      logic       last;
      logic [2:0] next_index;
   } hunt_result_type;

   typedef struct packed {
      logic [7:0] data_byte;
   } req_word_type;

   typedef struct packed {
      logic [15:0] max_packet_bytes;
   } csr_word_type;

   typedef struct packed {
      logic [7:0]  out_byte;
      logic [2:0]  phase;
      logic [15:0] packet_offset;
      logic [7:0]  tlv_number;
      logic        word_done;
      logic [3:0]  word_id;
      logic [31:0] word_value;
      logic        packet_end;
      logic [1:0]  error_code;
   } rsp_word_type;

endpackage

### src/rpd_stream_if.sv
// Valid/ready channel interface that carries one word of a given payload type.
`timescale 1ns / 1ps

interface rpd_stream_if #(
   parameter type payload_type = logic
) ();
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

### src/rpd_magic_match.sv
// Magic word matcher: compares one byte against the expected magic byte.
`timescale 1ns / 1ps

module rpd_magic_match
   import rpd_pkg::*;
(
   input  logic [7:0]      data_byte,
   input  logic [2:0]      magic_index,
   output hunt_result_type result
);

   always_comb begin
      result.hit        = (data_byte == MAGIC_WORD[magic_index]);
      result.last       = result.hit && (magic_index == 3'(MAGIC_BYTES - 1));
      result.next_index = 3'd0;
      if (result.hit) begin
         if (!result.last) begin
            result.next_index = magic_index + 3'd1;
         end
      end else if (data_byte == MAGIC_FIRST) begin
         // A mismatching byte may itself start a new magic word.
         result.next_index = 3'd1;
      end
   end

endmodule

### src/radar_packet_deframer.sv
// Top level of the radar packet deframer: byte stream in, one annotated word out per byte.
`timescale 1ns / 1ps

//  Channel   | Dir | Payload                                  | Notes
//  ----------+-----+------------------------------------------+-------------------------------
//  req_chan  | in  | data_byte                                | one stream byte per word
//  rsp_chan  | out | out_byte, phase, packet_offset, ...      | exactly one word per req word
//  csr_chan  | in  | max_packet_bytes                         | always ready, write when idle
//
//  The block takes one byte per clock cycle unless it stalls. A byte waits in the input
//  register and is decoded on its way into the result register, from which its result
//  word is offered. A stalled result register holds its word while the input register
//  takes one more byte; only when both are full does req_chan.ready drop.
//  Reset (synchronous, active high) puts the parser back into hunting for the magic word and
//  sets max_packet_bytes to 4096.

module radar_packet_deframer
   import rpd_pkg::*;
#(
   parameter int LENGTH_WIDTH = 16,
   parameter int MAX_TLVS     = 256
) (
   input  logic       clock,
   input  logic       reset,
   rpd_stream_if.sink   req_chan,
   rpd_stream_if.source rsp_chan,
   rpd_stream_if.sink   csr_chan
);

   // Packet lengths above the configured maximum are rejected; the maximum is further capped
   // by the length width, so the stored packet size never needs more than SizeWidth bits.
   localparam int SizeWidth = (LENGTH_WIDTH < 16) ? LENGTH_WIDTH : 16;
   localparam logic [15:0] LenCap = (LENGTH_WIDTH >= 16) ? 16'hFFFF :
                                    16'((32'd1 << LENGTH_WIDTH) - 32'd1);
   // The TLV counter must be able to hold the TLV limit itself.
   localparam int CountWidth = $clog2(MAX_TLVS + 1);

   // Handshake and pipeline registers.
   logic                  in_valid_ff;
   logic [7:0]            in_byte_ff;
   logic                  out_valid_ff, out_valid_in;
   rsp_word_type          out_word_ff, out_word_in;
   logic                  move;
   logic [15:0]           max_ff;

   // Parser state.
   sync_state_type        sync_ff, sync_in;
   logic [2:0]            magic_idx_ff, magic_idx_in;
   logic [15:0]           pos_ff, pos_in;
   logic [31:0]           shift_ff, shift_in;
   logic [SizeWidth-1:0]  size_ff, size_in;
   logic [CountWidth-1:0] tlv_limit_ff, tlv_limit_in;
   logic [CountWidth-1:0] tlv_cnt_ff, tlv_cnt_in;
   logic [2:0]            hdr_bytes_ff, hdr_bytes_in;
   logic [15:0]           remain_ff, remain_in;

   hunt_result_type       hunt;

   // A byte moves from the input register into the result register when the latter is free
   // or being emptied in the same cycle.
   assign move           = in_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !in_valid_ff || move;
   assign out_valid_in   = move || (out_valid_ff && !rsp_chan.ready);
   assign rsp_chan.valid   = out_valid_ff;
   assign rsp_chan.payload = out_word_ff;
   assign csr_chan.ready   = 1'b1;

   rpd_magic_match u_magic (
      .data_byte   (in_byte_ff),
      .magic_index (magic_idx_ff),
      .result      (hunt)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         max_ff       <= MAX_PACKET_RESET;
         sync_ff      <= SYNC_HUNT;
         magic_idx_ff <= 3'd0;
         pos_ff       <= 16'd0;
         size_ff      <= '0;
         tlv_limit_ff <= '0;
         tlv_cnt_ff   <= '0;
         hdr_bytes_ff <= 3'd0;
         remain_ff    <= 16'd0;
      end else begin
         in_valid_ff  <= req_chan.valid || (in_valid_ff && !move);
         out_valid_ff <= out_valid_in;
         if (csr_chan.valid) begin
            max_ff <= csr_chan.payload.max_packet_bytes;
         end
         if (move) begin
            sync_ff      <= sync_in;
            magic_idx_ff <= magic_idx_in;
            pos_ff       <= pos_in;
            size_ff      <= size_in;
            tlv_limit_ff <= tlv_limit_in;
            tlv_cnt_ff   <= tlv_cnt_in;
            hdr_bytes_ff <= hdr_bytes_in;
            remain_ff    <= remain_in;
         end
      end
   end

   // Payload registers need no reset.
   always_ff @(posedge clock) begin
      if (req_chan.ready) begin
         in_byte_ff <= req_chan.payload.data_byte;
      end
      if (move) begin
         shift_ff    <= shift_in;
         out_word_ff <= out_word_in;
      end
   end

   // Next parser state and result word for the byte in the input register.
   always_comb begin
      logic [4:0]            rel;
      logic [3:0]            wid;
      logic [15:0]           eff_len;
      logic [15:0]           tlv_len;
      logic [CountWidth-1:0] cnt_next;
      logic                  aborted;
      logic                  tlv_done;

      sync_in      = sync_ff;
      magic_idx_in = magic_idx_ff;
      pos_in       = pos_ff;
      shift_in     = shift_ff;
      size_in      = size_ff;
      tlv_limit_in = tlv_limit_ff;
      tlv_cnt_in   = tlv_cnt_ff;
      hdr_bytes_in = hdr_bytes_ff;
      remain_in    = remain_ff;

      out_word_in               = '0;
      out_word_in.out_byte      = in_byte_ff;
      out_word_in.phase         = PHASE_HUNT;
      out_word_in.error_code    = ERR_NONE;

      rel      = 5'(pos_ff - 16'd8);
      wid      = {1'b0, rel[4:2]};
      eff_len  = (max_ff > LenCap) ? LenCap : max_ff;
      // Saturated TLV length of the word that the current byte completes.
      tlv_len  = (|{in_byte_ff, shift_ff[31:24]}) ? 16'hFFFF : shift_ff[23:8];
      cnt_next = tlv_cnt_ff + CountWidth'(1);
      aborted  = 1'b0;
      tlv_done = 1'b0;

      if (sync_ff == SYNC_HUNT) begin
         magic_idx_in = hunt.next_index;
         if (hunt.hit) begin
            out_word_in.packet_offset = {13'd0, magic_idx_ff};
         end
         if (hunt.last) begin
            sync_in = SYNC_HEADER;
            pos_in  = 16'(MAGIC_BYTES);
         end
      end else begin
         out_word_in.packet_offset = pos_ff;
         shift_in = {in_byte_ff, shift_ff[31:8]};

         unique case (sync_ff)
            SYNC_HEADER: begin
               out_word_in.phase = PHASE_HEADER;
               if (rel[1:0] == 2'd3) begin
                  out_word_in.word_done  = 1'b1;
                  out_word_in.word_id    = wid;
                  out_word_in.word_value = shift_in;
                  if (wid == WID_LENGTH) begin
                     priority if (shift_in < 32'(HEADER_BYTES)) begin
                        out_word_in.error_code = ERR_SHORT;
                        aborted = 1'b1;
                     end else if (shift_in > {16'd0, eff_len}) begin
                        out_word_in.error_code = ERR_LONG;
                        aborted = 1'b1;
                     end else begin
                        size_in = SizeWidth'(shift_in);
                     end
                  end else if (wid == WID_TLV_COUNT) begin
                     tlv_limit_in = (shift_in >= 32'(MAX_TLVS)) ? CountWidth'(MAX_TLVS) :
                                    CountWidth'(shift_in);
                     tlv_cnt_in   = '0;
                     hdr_bytes_in = 3'd0;
                     remain_in    = 16'd0;
                     sync_in      = (tlv_limit_in == '0) ? SYNC_OTHER : SYNC_TLV;
                  end
               end
            end
            SYNC_TLV: begin
               out_word_in.tlv_number = 8'(tlv_cnt_ff);
               if (remain_ff != 16'd0) begin
                  out_word_in.phase = PHASE_TLV_DATA;
                  remain_in = remain_ff - 16'd1;
                  tlv_done  = (remain_ff == 16'd1);
               end else begin
                  out_word_in.phase = PHASE_TLV_HEAD;
                  hdr_bytes_in = hdr_bytes_ff + 3'd1;
                  priority if (hdr_bytes_ff == 3'd3) begin
                     out_word_in.word_done  = 1'b1;
                     out_word_in.word_id    = WID_TLV_TYPE;
                     out_word_in.word_value = shift_in;
                     if (shift_in > MAX_TLV_TYPE) begin
                        // Unknown type: the rest of the packet is not walked.
                        out_word_in.error_code = ERR_TLV_TYPE;
                        sync_in = SYNC_OTHER;
                     end
                  end else if (hdr_bytes_ff == 3'd7) begin
                     out_word_in.word_done  = 1'b1;
                     out_word_in.word_id    = WID_TLV_LENGTH;
                     out_word_in.word_value = shift_in;
                     remain_in = tlv_len;
                     tlv_done  = (tlv_len == 16'd0);
                  end else begin
                     out_word_in.word_done = 1'b0;
                  end
               end
               if (tlv_done) begin
                  tlv_cnt_in   = cnt_next;
                  hdr_bytes_in = 3'd0;
                  remain_in    = 16'd0;
                  if (cnt_next == tlv_limit_ff) begin
                     sync_in = SYNC_OTHER;
                  end
               end
            end
            SYNC_OTHER: begin
               out_word_in.phase      = PHASE_OTHER;
               out_word_in.tlv_number = 8'(tlv_cnt_ff);
            end
            default: begin
               out_word_in.phase = PHASE_HUNT;
            end
         endcase

         priority if (aborted) begin
            sync_in      = SYNC_HUNT;
            magic_idx_in = 3'd0;
            pos_in       = 16'd0;
         end else if ((pos_ff >= 16'd16) &&
                      ({1'b0, pos_ff} + 17'd1 == 17'(size_ff))) begin
            out_word_in.packet_end = 1'b1;
            sync_in      = SYNC_HUNT;
            magic_idx_in = 3'd0;
            pos_in       = 16'd0;
         end else begin
            pos_in = pos_ff + 16'd1;
         end
      end
   end

endmodule

### tb/radar_packet_deframer_checker.sv
// Scoreboard for the radar packet deframer: predicts every result word and compares it.
`timescale 1ns / 1ps

module radar_packet_deframer_checker
   import rpd_pkg::*;
#(
   parameter int LENGTH_WIDTH = 16,
   parameter int MAX_TLVS     = 256
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   input  logic         req_ready,
   input  req_word_type req_word,
   input  logic         rsp_valid,
   input  logic         rsp_ready,
   input  rsp_word_type rsp_word,
   input  logic         csr_valid,
   input  logic         csr_ready,
   input  csr_word_type csr_word,
   output int           mismatches,
   output int           words_checked,
   output int           outstanding
);

   localparam int REPORT_LIMIT = 10;
   localparam longint unsigned LENGTH_CAP = (64'd1 << LENGTH_WIDTH) - 64'd1;

   // Shadow copy of the deframer state.
   logic [15:0]    length_limit;
   sync_state_type deframe_state;
   logic [2:0]     magic_index;
   logic [15:0]    byte_pos;
   logic [31:0]    word_shift;
   logic [31:0]    packet_size;
   logic [31:0]    tlv_total;
   logic [31:0]    tlv_index;
   logic [2:0]     tlv_head_count;
   logic [15:0]    payload_left;

   rsp_word_type   annotated_bytes[$];

   function automatic logic [31:0] tlv_walk_limit();
      return (tlv_total < MAX_TLVS) ? tlv_total : MAX_TLVS;
   endfunction

   function automatic string word_text(rsp_word_type w);
      return $sformatf("byte %02h phase %0d offset %0d tlv %0d done %0b id %0d value %08h end %0b err %0d",
                       w.out_byte, w.phase, w.packet_offset, w.tlv_number, w.word_done,
                       w.word_id, w.word_value, w.packet_end, w.error_code);
   endfunction

   task automatic return_to_hunt();
      deframe_state = SYNC_HUNT;
      magic_index   = '0;
      byte_pos      = '0;
   endtask

   task automatic advance_tlv();
      tlv_index++;
      tlv_head_count = '0;
      payload_left   = '0;
      if (tlv_index >= tlv_walk_limit()) deframe_state = SYNC_OTHER;
   endtask

   // Works out the annotated word for one stream byte and moves the shadow state on.
   task automatic deframe_byte(input logic [7:0] data, output rsp_word_type w);
      logic             aborted;
      logic [15:0]      rel;
      logic [2:0]       head_byte;
      longint unsigned  eff_limit;
      w         = '0;
      w.out_byte = data;
      aborted   = 1'b0;
      if (deframe_state == SYNC_HUNT) begin
         if (data == MAGIC_WORD[magic_index]) begin
            w.packet_offset = 16'(magic_index);
            if (magic_index == 3'd7) begin
               deframe_state = SYNC_HEADER;
               byte_pos      = 16'd8;
               word_shift    = '0;
               magic_index   = '0;
            end else begin
               magic_index = magic_index + 3'd1;
            end
         end else begin
            magic_index = (data == MAGIC_FIRST) ? 3'd1 : 3'd0;
         end
      end else begin
         w.packet_offset = byte_pos;
         word_shift      = {data, word_shift[31:8]};
         case (deframe_state)
            SYNC_HEADER: begin
               rel     = byte_pos - 16'd8;
               w.phase = PHASE_HEADER;
               if (rel[1:0] == 2'd3) begin
                  w.word_done  = 1'b1;
                  w.word_id    = rel[5:2];
                  w.word_value = word_shift;
                  if (w.word_id == WID_LENGTH) begin
                     eff_limit = (length_limit > LENGTH_CAP) ? LENGTH_CAP : length_limit;
                     if (word_shift < HEADER_BYTES) begin
                        w.error_code = ERR_SHORT;
                        aborted      = 1'b1;
                     end else if (longint'(word_shift) > eff_limit) begin
                        w.error_code = ERR_LONG;
                        aborted      = 1'b1;
                     end else begin
                        packet_size = word_shift;
                     end
                  end else if (w.word_id == WID_TLV_COUNT) begin
                     tlv_total      = word_shift;
                     tlv_index      = '0;
                     tlv_head_count = '0;
                     payload_left   = '0;
                     deframe_state  = (tlv_walk_limit() == 0) ? SYNC_OTHER : SYNC_TLV;
                  end
               end
            end
            SYNC_TLV: begin
               w.tlv_number = tlv_index[7:0];
               if (payload_left > 0) begin
                  w.phase = PHASE_TLV_DATA;
                  payload_left--;
                  if (payload_left == 0) advance_tlv();
               end else begin
                  w.phase        = PHASE_TLV_HEAD;
                  head_byte      = tlv_head_count;
                  tlv_head_count = head_byte + 3'd1;
                  if (head_byte == 3'd3) begin
                     w.word_done  = 1'b1;
                     w.word_id    = WID_TLV_TYPE;
                     w.word_value = word_shift;
                     if (word_shift > MAX_TLV_TYPE) begin
                        w.error_code  = ERR_TLV_TYPE;
                        deframe_state = SYNC_OTHER;
                     end
                  end else if (head_byte == 3'd7) begin
                     w.word_done  = 1'b1;
                     w.word_id    = WID_TLV_LENGTH;
                     w.word_value = word_shift;
                     payload_left = (word_shift > 32'hFFFF) ? 16'hFFFF : word_shift[15:0];
                     if (payload_left == 0) advance_tlv();
                  end
               end
            end
            default: begin
               w.phase      = PHASE_OTHER;
               w.tlv_number = tlv_index[7:0];
            end
         endcase

         if (aborted) begin
            return_to_hunt();
         end else if (byte_pos >= 16'd16 && {16'd0, byte_pos} + 32'd1 == packet_size) begin
            w.packet_end = 1'b1;
            return_to_hunt();
         end else begin
            byte_pos = byte_pos + 16'd1;
         end
      end
   endtask

   always @(posedge clock) begin
      rsp_word_type predicted;
      rsp_word_type oldest;
      string        wrong;
      if (reset) begin
         length_limit   = MAX_PACKET_RESET;
         return_to_hunt();
         word_shift     = '0;
         packet_size    = '0;
         tlv_total      = '0;
         tlv_index      = '0;
         tlv_head_count = '0;
         payload_left   = '0;
         annotated_bytes.delete();
         mismatches     = 0;
         words_checked  = 0;
      end else begin
         if (csr_valid && csr_ready) length_limit = csr_word.max_packet_bytes;
         if (req_valid && req_ready) begin
            deframe_byte(req_word.data_byte, predicted);
            annotated_bytes.push_back(predicted);
         end
         if (rsp_valid && rsp_ready) begin
            words_checked++;
            if (annotated_bytes.size() == 0) begin
               mismatches++;
               if (mismatches <= REPORT_LIMIT)
                  $display("Unexpected result word: %s", word_text(rsp_word));
            end else begin
               oldest = annotated_bytes.pop_front();
               wrong  = "";
               if (rsp_word.out_byte !== oldest.out_byte) wrong = {wrong, " out_byte"};
               if (rsp_word.phase !== oldest.phase) wrong = {wrong, " phase"};
               if (rsp_word.packet_offset !== oldest.packet_offset) wrong = {wrong, " offset"};
               if (rsp_word.tlv_number !== oldest.tlv_number) wrong = {wrong, " tlv_number"};
               if (rsp_word.word_done !== oldest.word_done) wrong = {wrong, " word_done"};
               if (rsp_word.word_id !== oldest.word_id) wrong = {wrong, " word_id"};
               if (rsp_word.word_value !== oldest.word_value) wrong = {wrong, " word_value"};
               if (rsp_word.packet_end !== oldest.packet_end) wrong = {wrong, " packet_end"};
               if (rsp_word.error_code !== oldest.error_code) wrong = {wrong, " error_code"};
               if (wrong != "") begin
                  mismatches++;
                  if (mismatches <= REPORT_LIMIT) begin
                     $display("Mismatch on result word %0d in%s", words_checked, wrong);
                     $display("   expected %s", word_text(oldest));
                     $display("   actual   %s", word_text(rsp_word));
                  end
               end
            end
         end
      end
      outstanding <= annotated_bytes.size();
   end

endmodule

### tb/radar_packet_deframer_tb.sv
// Top of the radar packet deframer testbench: clock, reset, stimulus, stalls and verdict.
`timescale 1ns / 1ps

// The stream fed to the block is made of framed packets: the magic word, a 28-byte header
// whose length and TLV count words steer the parse, a chain of TLVs and random fill up to
// the packet length. Between packets sit stray bytes and broken magic words. A short
// directed part covers the corner cases first; random packets then follow under several
// settings of the packet length limit. The checker beside the block predicts every word.

module radar_packet_deframer_tb;
   import rpd_pkg::*;

   localparam int CLOCK_HIGH_NS   = 2;
   localparam int CLOCK_LOW_NS    = 2;
   localparam int RESET_CYCLES    = 11;
   localparam int CYCLE_LIMIT     = 400000;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int DRAIN_CYCLES    = 8;
   localparam int MAX_TLVS        = 256;
   localparam int PHASE_BYTES     = 100;
   localparam int PAYLOAD_CAP     = 24;

   // Ways the result side applies back-pressure.
   typedef enum logic [1:0] {
      RX_OPEN,
      RX_HALF,
      RX_SPARSE,
      RX_PERIODIC
   } rx_stall_mode_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   rpd_stream_if #(.payload_type(req_word_type)) req_if ();
   rpd_stream_if #(.payload_type(rsp_word_type)) rsp_if ();
   rpd_stream_if #(.payload_type(csr_word_type)) csr_if ();

   int mismatches;
   int words_checked;
   int outstanding;

   int          cycle_count;
   int          burst_left       = 0;
   int          bytes_sent       = 0;
   int          packets_sent     = 0;
   int          limits_used      = 0;
   int          hold_offs_asked  = 0;
   int          hold_offs_done   = 0;
   logic [15:0] length_limit_now = MAX_PACKET_RESET;

   // Bytes of the stream that are built but not yet sent, and the packet being built.
   logic [7:0]  stream_bytes[$];
   int          packet_start;
   logic [31:0] packet_len_word;

   always begin
      #CLOCK_LOW_NS clock = 1'b1;
      #CLOCK_HIGH_NS clock = 1'b0;
   end

   radar_packet_deframer i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if.sink),
      .rsp_chan (rsp_if.source),
      .csr_chan (csr_if.sink)
   );

   radar_packet_deframer_checker #(
      .MAX_TLVS (MAX_TLVS)
   ) i_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_if.valid),
      .req_ready     (req_if.ready),
      .req_word      (req_if.payload),
      .rsp_valid     (rsp_if.valid),
      .rsp_ready     (rsp_if.ready),
      .rsp_word      (rsp_if.payload),
      .csr_valid     (csr_if.valid),
      .csr_ready     (csr_if.ready),
      .csr_word      (csr_if.payload),
      .mismatches    (mismatches),
      .words_checked (words_checked),
      .outstanding   (outstanding)
   );

   // Appends a 32-bit header or TLV word, least significant byte first.
   task automatic put_word(input logic [31:0] value);
      for (int i = 0; i < 4; i++) stream_bytes.push_back(value[8*i +: 8]);
   endtask

   // Header words that the block only reports get their extremes now and then.
   function automatic logic [31:0] header_filler();
      int pick;
      pick = $urandom_range(0, 5);
      if (pick == 0) return 32'h0000_0000;
      if (pick == 1) return 32'hFFFF_FFFF;
      return $urandom;
   endfunction

   // Opens a packet: the magic word and the full header, with the length and TLV count
   // words as given. The other header words are random.
   task automatic start_packet(input logic [31:0] len_word, input logic [31:0] count_word);
      packet_start    = stream_bytes.size();
      packet_len_word = len_word;
      for (int i = 0; i < MAGIC_BYTES; i++) stream_bytes.push_back(MAGIC_WORD[i]);
      put_word(header_filler());
      put_word(len_word);
      repeat (4) put_word(header_filler());
      put_word(count_word);
      packets_sent++;
   endtask

   // A TLV header and as much of its payload as fits in a short packet.
   task automatic put_tlv(input logic [31:0] tlv_type, input logic [31:0] tlv_len);
      put_word(tlv_type);
      put_word(tlv_len);
      repeat ((tlv_len > PAYLOAD_CAP) ? PAYLOAD_CAP : tlv_len)
         stream_bytes.push_back(8'($urandom_range(0, 255)));
   endtask

   // Closes the packet at its length word. A packet whose length the block rejects is
   // cut a little after the length word; the rest would only be hunted through.
   task automatic end_packet();
      int target;
      if (packet_len_word >= HEADER_BYTES && packet_len_word <= {16'd0, length_limit_now})
         target = packet_len_word;
      else
         target = 16 + $urandom_range(0, 20);
      while (stream_bytes.size() - packet_start < target)
         stream_bytes.push_back(8'($urandom_range(0, 255)));
      while (stream_bytes.size() - packet_start > target) void'(stream_bytes.pop_back());
   endtask

   // Junk between packets: often the start of a magic word broken off by a wrong byte.
   task automatic put_noise();
      int matched;
      matched = $urandom_range(0, 7);
      for (int i = 0; i < matched; i++) stream_bytes.push_back(MAGIC_WORD[i]);
      stream_bytes.push_back($urandom_range(0, 1) ? MAGIC_FIRST : 8'($urandom_range(0, 255)));
      repeat ($urandom_range(0, 4)) stream_bytes.push_back(8'($urandom_range(0, 255)));
   endtask

   function automatic logic [31:0] random_tlv_type();
      if ($urandom_range(0, 11) != 0) return $urandom_range(0, 3);
      return $urandom_range(0, 1) ? (MAX_TLV_TYPE + 32'd1) : ($urandom | 32'h0000_0004);
   endfunction

   function automatic logic [31:0] random_tlv_length();
      int pick;
      pick = $urandom_range(0, 11);
      if (pick == 0) return $urandom | 32'h0001_0000;
      if (pick == 1) return 32'h0000_FFFF;
      return $urandom_range(0, 12);
   endfunction

   // Mostly well-formed packets sized for the current limit; a few carry bad lengths.
   task automatic put_random_packet();
      int          pick;
      int          n_tlvs;
      int          top_len;
      logic [31:0] len_word;
      logic [31:0] count_word;
      pick    = $urandom_range(0, 19);
      top_len = (length_limit_now < 160) ? length_limit_now : 160;
      case (pick)
         0:       len_word = $urandom_range(0, HEADER_BYTES - 1);
         1:       len_word = {16'd0, length_limit_now} + $urandom_range(1, 500);
         2:       len_word = $urandom | 32'h0001_0000;
         3:       len_word = (length_limit_now >= HEADER_BYTES && length_limit_now <= 400)
                             ? length_limit_now : HEADER_BYTES;
         default: len_word = (length_limit_now < HEADER_BYTES)
                             ? $urandom_range(HEADER_BYTES, 200)
                             : $urandom_range(HEADER_BYTES, top_len);
      endcase
      pick = $urandom_range(0, 9);
      if (pick == 0)      count_word = '0;
      else if (pick == 1) count_word = $urandom | 32'h0000_0100;
      else                count_word = $urandom_range(1, 4);
      n_tlvs = (count_word > 4) ? $urandom_range(1, 6) : count_word + $urandom_range(0, 1);
      start_packet(len_word, count_word);
      repeat (n_tlvs) put_tlv(random_tlv_type(), random_tlv_length());
      end_packet();
      if ($urandom_range(0, 2) == 0) put_noise();
   endtask

   // Offers one byte and waits for it to be taken. The sender works in bursts; at the
   // start of each burst valid may drop for a random gap.
   task automatic send_byte(input logic [7:0] value);
      int gap;
      if (burst_left == 0) begin
         gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                                  : $urandom_range(1, 24);
         if (gap > 0) begin
            @(negedge clock);
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      @(negedge clock);
      req_if.valid             <= 1'b1;
      req_if.payload.data_byte <= value;
      do @(posedge clock); while (!req_if.ready);
      burst_left--;
      bytes_sent++;
   endtask

   task automatic send_stream();
      while (stream_bytes.size() > 0) send_byte(stream_bytes.pop_front());
   endtask

   // The limit may only change while the block is idle. Every byte yields one result,
   // so the block is idle once no result is outstanding.
   task automatic write_length_limit(input logic [15:0] limit);
      @(negedge clock);
      req_if.valid <= 1'b0;
      while (outstanding != 0) @(posedge clock);
      @(negedge clock);
      csr_if.valid                    <= 1'b1;
      csr_if.payload.max_packet_bytes <= limit;
      do @(posedge clock); while (!csr_if.ready);
      @(negedge clock);
      csr_if.valid     <= 1'b0;
      length_limit_now = limit;
      limits_used++;
   endtask

   // Result side: ready follows a changing stall pattern. On request it holds off for a
   // long stretch so that the block fills up and pushes back on its input.
   initial begin : result_stall
      int                seg_left;
      int                hold_left;
      rx_stall_mode_type stall_mode;
      seg_left     = 0;
      hold_left    = 0;
      stall_mode   = RX_OPEN;
      rsp_if.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_offs_done < hold_offs_asked) begin
            hold_offs_done++;
            hold_left = HOLD_OFF_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_if.ready <= 1'b0;
         end else begin
            if (seg_left == 0) begin
               seg_left   = $urandom_range(8, 100);
               stall_mode = rx_stall_mode_type'($urandom_range(0, 3));
            end
            seg_left--;
            case (stall_mode)
               RX_OPEN:   rsp_if.ready <= 1'b1;
               RX_HALF:   rsp_if.ready <= 1'($urandom_range(0, 1));
               RX_SPARSE: rsp_if.ready <= ($urandom_range(0, 3) == 0);
               default:   rsp_if.ready <= (seg_left % 3 != 0);
            endcase
         end
      end
   end

   // Cycle counter that ends a hung run.
   initial begin : watchdog
      for (cycle_count = 0; cycle_count < CYCLE_LIMIT; cycle_count++) @(posedge clock);
      $display("Run stopped after %0d cycles with %0d results outstanding.",
               cycle_count, outstanding);
      $display("RESULT: ERROR");
      $finish;
   end

   initial begin : stimulus
      logic [15:0] limit_plan[6];
      int          phase_start;
      req_if.valid   = 1'b0;
      req_if.payload = '0;
      csr_if.valid   = 1'b0;
      csr_if.payload = '0;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part, under the limit the block comes out of reset with.
      // Stray bytes at both ends of the byte range while hunting.
      stream_bytes = '{8'h00, 8'hFF, 8'h80, 8'h01};
      // A false start: where the fourth magic byte belongs a 0x02 arrives, so the match
      // picks up again after it. The packet is the shortest legal one, with no TLVs.
      stream_bytes.push_back(8'h02);
      stream_bytes.push_back(8'h01);
      stream_bytes.push_back(8'h04);
      start_packet(HEADER_BYTES, 32'd0);
      end_packet();
      // A magic word broken by a byte other than 0x02, then a doubled first byte.
      stream_bytes.push_back(8'h02);
      stream_bytes.push_back(8'h01);
      stream_bytes.push_back(8'h04);
      stream_bytes.push_back(8'h03);
      stream_bytes.push_back(8'h06);
      stream_bytes.push_back(8'hFF);
      stream_bytes.push_back(8'h02);
      // Length word one short of a header, then as large as it gets.
      start_packet(HEADER_BYTES - 1, 32'd1);
      end_packet();
      start_packet(32'hFFFF_FFFF, 32'd1);
      end_packet();
      // An empty TLV, one with payload, and a third one past the TLV count.
      start_packet(32'd72, 32'd2);
      put_tlv(32'd3, 32'd0);
      put_tlv(32'd0, 32'd5);
      put_tlv(32'd1, 32'd2);
      end_packet();
      // An unknown TLV type stops the walk for the rest of the packet.
      start_packet(32'd60, 32'd3);
      put_tlv(MAX_TLV_TYPE + 32'd1, 32'd2);
      put_tlv(32'd1, 32'd1);
      end_packet();
      // A TLV length beyond 16 bits; the packet length cuts its payload short.
      start_packet(32'd56, 32'd1);
      put_tlv(32'd2, 32'hFFFF_FFFF);
      end_packet();
      send_stream();

      // Random part, one phase per limit: the smallest legal one, the largest, one that
      // rejects every packet, two random ones and the reset value.
      limit_plan = '{16'd36, 16'hFFFF, 16'd0, 16'($urandom_range(37, 300)),
                     16'($urandom_range(301, 65534)), MAX_PACKET_RESET};
      for (int phase = 0; phase < 6; phase++) begin
         write_length_limit(limit_plan[phase]);
         // One long stall on the result side while bytes keep coming.
         if (phase == 1) hold_offs_asked++;
         phase_start = bytes_sent;
         while (bytes_sent - phase_start < PHASE_BYTES) begin
            put_random_packet();
            send_stream();
         end
      end

      @(negedge clock);
      req_if.valid <= 1'b0;
      while (outstanding != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Covered %0d stream bytes in %0d framed packets under %0d length limits,",
               bytes_sent, packets_sent, limits_used + 1);
      $display("with %0d result words checked and %0d mismatches in %0d cycles.",
               words_checked, mismatches, cycle_count);
      if (mismatches == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

### filelist.f
src/rpd_pkg.sv
src/rpd_stream_if.sv
src/rpd_magic_match.sv
src/radar_packet_deframer.sv
tb/radar_packet_deframer_checker.sv
tb/radar_packet_deframer_tb.sv
